// ----- rtl/core/qts_pkg.sv -----
package qts_pkg;

	// Character codes with a special meaning on the command line.
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;

	// Result kinds.
	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_EOT  = 2'd1;
	localparam logic [1:0] KIND_EOL  = 2'd2;

	// One input item causes at most this many results.
	localparam int unsigned RES_DEPTH = 4;
	localparam int unsigned CNT_W     = $clog2(RES_DEPTH + 1);
	localparam int unsigned IDX_W     = $clog2(RES_DEPTH);

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] token_byte;
		logic       last_result;
	} res_t;

	typedef struct packed {
		logic quoted;
		logic quote_is_single;
		logic backslash_pending;
		logic token_open;
		logic comment_skip;
	} scan_state_t;

endpackage

// ----- rtl/core/qts_item_if.sv -----
interface qts_item_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       has_char;
	logic       end_of_line;

	modport source (output valid, output char_code, output has_char, output end_of_line,
		input ready);
	modport sink (input valid, input char_code, input has_char, input end_of_line,
		output ready);
endinterface

// ----- rtl/core/qts_result_if.sv -----
interface qts_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] token_byte;
	logic       last_result;

	modport source (output valid, output kind, output token_byte, output last_result,
		input ready);
	modport sink (input valid, input kind, input token_byte, input last_result,
		output ready);
endinterface

// ----- rtl/core/quoted_token_splitter.sv -----
// Channel  | Direction | Payload                              | Handshake
// items    | in        | char_code, has_char, end_of_line     | valid/ready
// results  | out       | kind, token_byte, last_result        | valid/ready
//
// An accepted beat is held in an input register until the result buffer is free; the scanner
// logic decodes it against the scan state and writes all of its results (up to four) at once
// into a small result buffer that drains one beat per cycle while results.ready is high.
// With results.ready high, one input beat per cycle is taken while each beat causes at most one
// result; more results stall the input until the single result port has sent all but one.
// arst_n clears the scan state, the input valid flag and the result buffer count at once.
// Either side may stall at any time without losing or repeating a beat.
module quoted_token_splitter
	import qts_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	qts_item_if.sink     items,
	qts_result_if.source results
);

	// Input register: one item waiting to be scanned.
	logic        valid_s1;
	logic [7:0]  char_s1;
	logic        has_char_s1;
	logic        eol_s1;

	// Scan state carried from item to item.
	scan_state_t state_q;

	// Result buffer: entry 0 is the beat on the output port.
	res_t             res_q [RES_DEPTH];
	logic [CNT_W-1:0] cnt_q;

	// Next-state and results of the item in the input register.
	scan_state_t      state_d;
	res_t             new_res [RES_DEPTH];
	logic [CNT_W-1:0] new_cnt;

	logic out_fire;
	logic buf_free;
	logic advance;

	assign out_fire = results.valid && results.ready;
	// The buffer can take new results when empty or when its last beat leaves now.
	assign buf_free = (cnt_q == '0) || ((cnt_q == CNT_W'(1)) && results.ready);
	assign advance  = valid_s1 && buf_free;
	assign items.ready = !valid_s1 || advance;

	// Scanner: decodes one item against the current state. Every path below pushes at
	// most four results in order, mirroring the order in which they are decided.
	always_comb begin
		logic [7:0]       closer;
		logic [CNT_W-1:0] n;
		res_t             slot [RES_DEPTH];
		logic [7:0]       c;

		c      = char_s1;
		state_d = state_q;
		n      = '0;
		for (int i = 0; i < RES_DEPTH; i++) begin
			slot[i] = '{kind: KIND_BYTE, token_byte: 8'h00, last_result: 1'b0};
		end
		closer = state_q.quote_is_single ? CH_SQUOTE : CH_DQUOTE;

		if (has_char_s1 && !state_q.comment_skip) begin
			if (state_q.quoted) begin
				if (state_q.backslash_pending) begin
					// An escape: known pairs collapse to one byte, others keep the backslash.
					state_d.backslash_pending = 1'b0;
					state_d.token_open = 1'b1;
					if (c == CH_DQUOTE || c == CH_SQUOTE || c == CH_BSLASH) begin
						slot[n[IDX_W-1:0]].token_byte = c;
						n = n + CNT_W'(1);
					end else if (c == CH_N) begin
						slot[n[IDX_W-1:0]].token_byte = CH_LF;
						n = n + CNT_W'(1);
					end else if (c == CH_T) begin
						slot[n[IDX_W-1:0]].token_byte = CH_TAB;
						n = n + CNT_W'(1);
					end else begin
						slot[n[IDX_W-1:0]].token_byte = CH_BSLASH;
						n = n + CNT_W'(1);
						slot[n[IDX_W-1:0]].token_byte = c;
						n = n + CNT_W'(1);
					end
				end else if (c == closer) begin
					state_d.quoted = 1'b0;
					state_d.quote_is_single = 1'b0;
				end else if (c == CH_BSLASH) begin
					state_d.backslash_pending = 1'b1;
				end else begin
					slot[n[IDX_W-1:0]].token_byte = c;
					n = n + CNT_W'(1);
					state_d.token_open = 1'b1;
				end
			end else begin
				if (c == CH_DQUOTE || c == CH_SQUOTE) begin
					state_d.quoted = 1'b1;
					state_d.quote_is_single = (c == CH_SQUOTE);
				end else if (c == CH_HASH && !state_q.token_open) begin
					// A comment only starts at the head of a token.
					state_d.comment_skip = 1'b1;
				end else if (c == CH_SPACE) begin
					if (state_q.token_open) begin
						slot[n[IDX_W-1:0]].kind = KIND_EOT;
						n = n + CNT_W'(1);
					end
					state_d.token_open = 1'b0;
				end else begin
					slot[n[IDX_W-1:0]].token_byte = c;
					n = n + CNT_W'(1);
					state_d.token_open = 1'b1;
				end
			end
		end

		if (eol_s1) begin
			// A dangling backslash in an unclosed quote is kept as a literal byte.
			if (state_d.backslash_pending && state_d.quoted && !state_d.comment_skip) begin
				slot[n[IDX_W-1:0]].token_byte = CH_BSLASH;
				n = n + CNT_W'(1);
				state_d.token_open = 1'b1;
			end
			if (state_d.token_open) begin
				slot[n[IDX_W-1:0]].kind = KIND_EOT;
				n = n + CNT_W'(1);
			end
			slot[n[IDX_W-1:0]].kind = KIND_EOL;
			n = n + CNT_W'(1);
			state_d = '0;
		end

		if (n != '0) begin
			slot[IDX_W'(n - CNT_W'(1))].last_result = 1'b1;
		end

		new_res = slot;
		new_cnt = n;
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			char_s1     <= items.char_code;
			has_char_s1 <= items.has_char;
			eol_s1      <= items.end_of_line;
		end
	end

	// Scan state advances once per scanned item, whether or not it caused results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_d;
		end
	end

	// Result buffer count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (advance) begin
			cnt_q <= new_cnt;
		end else if (out_fire) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// Result buffer payload: loaded whole, then shifted toward the port.
	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= new_res;
		end else if (out_fire) begin
			for (int i = 0; i < RES_DEPTH - 1; i++) begin
				res_q[i] <= res_q[i+1];
			end
		end
	end

	assign results.valid       = (cnt_q != '0);
	assign results.kind        = res_q[0].kind;
	assign results.token_byte  = res_q[0].token_byte;
	assign results.last_result = res_q[0].last_result;

endmodule

// ----- rtl/core/qts_checker.sv -----
module qts_checker
	import qts_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] out_kind,
	input logic [7:0] out_token_byte,
	input logic       out_last_result
);

	// A stalled result beat keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_kind)
			&& $stable(out_token_byte) && $stable(out_last_result))
		else $error("result beat changed while stalled");

	// Only the three defined kinds are ever shown.
	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_kind == KIND_BYTE || out_kind == KIND_EOT || out_kind == KIND_EOL))
		else $error("undefined result kind");

	// Marks carry no byte.
	a_mark_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind != KIND_BYTE |-> out_token_byte == 8'h00)
		else $error("end mark with nonzero byte");

	// End of line is always the final result of its item.
	a_eol_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == KIND_EOL |-> out_last_result)
		else $error("end of line not flagged last");

	// A delivered end of line is never directly followed by an end of token.
	a_no_eot_after_eol: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_kind == KIND_EOL ##1 out_valid
			|-> out_kind != KIND_EOT)
		else $error("end of token at start of line");

endmodule

bind quoted_token_splitter qts_checker u_qts_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (results.valid),
	.out_ready       (results.ready),
	.out_kind        (results.kind),
	.out_token_byte  (results.token_byte),
	.out_last_result (results.last_result)
);

// ----- verif/tb_quoted_token_splitter.sv -----
module tb_quoted_token_splitter;
	import qts_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Number of cycles in a row with no beat moving on either channel before the
	// run is declared hung. A correct run never comes close: the longest quiet
	// stretch comes from random stalls on both sides.
	localparam int unsigned HANG_LIMIT = 2000;
	// Cycles allowed after the last expected beat, to catch stray extra results.
	localparam int unsigned DRAIN_CYCLES = 16;
	// Number of real (non-empty) command line items in the random part.
	localparam int unsigned RANDOM_ITEMS = 150;
	// Only the first few mismatches are printed; the rest are only counted.
	localparam int unsigned MAX_REPORTS = 10;
	// Marks a directed row whose results come from the predictor instead of the table.
	localparam int FROM_PREDICTOR = -1;

	logic clk = 1'b0;
	logic arst_n;

	qts_item_if   items();
	qts_result_if results();

	quoted_token_splitter dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items.sink),
		.results (results.source)
	);

	always #5ns clk = ~clk;

	// ------------------------------------------------------------------------
	// Token predictor.
	// It tracks the scanner state of the line being typed and, for every item
	// accepted on the input channel, appends the results that item must cause
	// to the queue of token beats still due on the output channel.
	// ------------------------------------------------------------------------
	scan_state_t scan;
	res_t        burst[$];      // results of the item being predicted
	res_t        beats_due[$];  // results expected on the output, oldest first

	function automatic res_t beat(logic [1:0] k, logic [7:0] b, logic last);
		res_t r;
		r.kind        = k;
		r.token_byte  = b;
		r.last_result = last;
		return r;
	endfunction

	function automatic void put_result(logic [1:0] k, logic [7:0] b);
		burst.insert(burst.size(), beat(k, b, 1'b0));
	endfunction

	// Any byte that lands in a token makes the token non-empty.
	function automatic void put_token_byte(logic [7:0] b);
		put_result(KIND_BYTE, b);
		scan.token_open = 1'b1;
	endfunction

	function automatic void scan_char(logic [7:0] c);
		logic [7:0] closer;
		closer = scan.quote_is_single ? CH_SQUOTE : CH_DQUOTE;
		if (scan.comment_skip) begin
			// The rest of the line is a comment and is dropped.
		end else if (scan.quoted) begin
			if (scan.backslash_pending) begin
				scan.backslash_pending = 1'b0;
				if (c == CH_DQUOTE || c == CH_SQUOTE || c == CH_BSLASH)
					put_token_byte(c);
				else if (c == CH_N)
					put_token_byte(CH_LF);
				else if (c == CH_T)
					put_token_byte(CH_TAB);
				else begin
					// Unknown escape: the backslash stays, then the byte is taken as is.
					put_token_byte(CH_BSLASH);
					put_token_byte(c);
				end
			end else if (c == closer) begin
				scan.quoted          = 1'b0;
				scan.quote_is_single = 1'b0;
			end else if (c == CH_BSLASH) begin
				scan.backslash_pending = 1'b1;
			end else begin
				put_token_byte(c);
			end
		end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
			scan.quoted          = 1'b1;
			scan.quote_is_single = (c == CH_SQUOTE);
		end else if (c == CH_HASH && !scan.token_open) begin
			scan.comment_skip = 1'b1;
		end else if (c == CH_SPACE) begin
			if (scan.token_open)
				put_result(KIND_EOT, 8'h00);
			scan.token_open = 1'b0;
		end else begin
			put_token_byte(c);
		end
	endfunction

	// Fills burst with the results of one item and advances the scan state.
	function automatic void predict_tokens(logic [7:0] c, logic has_char, logic eol);
		burst.delete();
		if (has_char)
			scan_char(c);
		if (eol) begin
			// A backslash left waiting in an open quote is kept as a literal.
			if (scan.backslash_pending && scan.quoted && !scan.comment_skip)
				put_token_byte(CH_BSLASH);
			if (scan.token_open)
				put_result(KIND_EOT, 8'h00);
			put_result(KIND_EOL, 8'h00);
			scan = '0;
		end
		if (burst.size() > 0)
			burst[burst.size() - 1].last_result = 1'b1;
	endfunction

	// ------------------------------------------------------------------------
	// Failure bookkeeping.
	// ------------------------------------------------------------------------
	int unsigned mismatches = 0;

	function automatic void report(string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t mismatch: %s", $realtime, msg);
	endfunction

	// ------------------------------------------------------------------------
	// Output side.
	// The ready line stalls in about one cycle of ten, except while the
	// stimulus asks for a steady stretch. Each accepted result beat is held
	// against the oldest expectation, field by field.
	// ------------------------------------------------------------------------
	logic steady = 1'b0;

	always @(posedge clk) begin
		if (!arst_n)
			results.ready <= 1'b0;
		else
			results.ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 10);
	end

	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n && results.valid && results.ready) begin
			got = beat(results.kind, results.token_byte, results.last_result);
			if (beats_due.size() == 0) begin
				report($sformatf("unexpected result kind=%0d byte=%02h last=%0b",
					got.kind, got.token_byte, got.last_result));
			end else begin
				want = beats_due.pop_front();
				if (got.kind !== want.kind)
					report($sformatf("kind: expected %0d, got %0d", want.kind, got.kind));
				if (got.token_byte !== want.token_byte)
					report($sformatf("token_byte: expected %02h, got %02h",
						want.token_byte, got.token_byte));
				if (got.last_result !== want.last_result)
					report($sformatf("last_result: expected %0b, got %0b",
						want.last_result, got.last_result));
			end
		end
	end

	// ------------------------------------------------------------------------
	// Hang watchdog: any beat on either channel restarts the count.
	// ------------------------------------------------------------------------
	int unsigned quiet_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (items.valid && items.ready) || (results.valid && results.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= HANG_LIMIT) begin
			$display("timeout: no beat moved for %0d cycles", HANG_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------------
	// Input side.
	// ------------------------------------------------------------------------

	// Presents one item and returns at the edge where it is taken. Before the
	// item, the valid line may drop at random so that gaps hit every phase of the scanner
	// and of the result buffer. The valid line is written once per edge at most, so a
	// back-to-back item simply keeps it high.
	task automatic offer_item(input logic [7:0] c, input logic has_char, input logic eol);
		while (!steady && $urandom_range(0, 99) < 10) begin
			items.valid <= 1'b0;
			@(posedge clk);
		end
		items.valid       <= 1'b1;
		items.char_code   <= c;
		items.has_char    <= has_char;
		items.end_of_line <= eol;
		@(posedge clk);
		while (!items.ready)
			@(posedge clk);
	endtask

	// Sends an item and queues what the predictor says it produces.
	task automatic send_predicted(input logic [7:0] c, input logic has_char, input logic eol);
		offer_item(c, has_char, eol);
		predict_tokens(c, has_char, eol);
		foreach (burst[i])
			beats_due.insert(beats_due.size(), burst[i]);
	endtask

	// Command line bytes, weighted toward the characters that steer the scanner
	// so that quotes, escapes and comments show up in most lines. A share of
	// fully random bytes covers every bit of the byte field.
	function automatic logic [7:0] pick_line_char();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 16)
			return CH_SPACE;
		else if (roll < 22)
			return CH_DQUOTE;
		else if (roll < 28)
			return CH_SQUOTE;
		else if (roll < 36)
			return CH_BSLASH;
		else if (roll < 40)
			return CH_HASH;
		else if (roll < 44)
			return CH_N;
		else if (roll < 48)
			return CH_T;
		else if (roll < 80)
			return 8'h61 + 8'($urandom_range(0, 25));
		else
			return 8'($urandom);
	endfunction

	// One row of the directed part. Rows with want_count set to a number carry
	// their results typed in; the others are checked against the predictor.
	typedef struct {
		logic [7:0] char_code;
		logic       has_char;
		logic       end_of_line;
		int         want_count;
		res_t [2:0] want;
	} step_t;

	step_t directed_steps[$];

	function automatic void plan(logic [7:0] c, logic has_char, logic eol,
		int n = FROM_PREDICTOR, res_t w0 = '0, res_t w1 = '0, res_t w2 = '0);
		step_t s;
		s.char_code   = c;
		s.has_char    = has_char;
		s.end_of_line = eol;
		s.want_count  = n;
		s.want        = {w2, w1, w0};
		directed_steps.insert(directed_steps.size(), s);
	endfunction

	initial begin
		int unsigned items_sent;
		int unsigned line_len;
		logic        line_closed;
		logic        eol;

		items.valid       <= 1'b0;
		items.char_code   <= 8'h00;
		items.has_char    <= 1'b0;
		items.end_of_line <= 1'b0;
		arst_n            <= 1'b0;
		scan = '0;

		// Directed part. The first rows start from the reset state, so their
		// results can be written down directly.
		// A bare end of line on an empty line gives only the end-of-line mark.
		plan(8'h00, 1'b0, 1'b1, 1, beat(KIND_EOL, 8'h00, 1'b1));
		// Extreme byte values are ordinary token bytes.
		plan(8'hFF, 1'b1, 1'b0, 1, beat(KIND_BYTE, 8'hFF, 1'b1));
		plan(8'h00, 1'b1, 1'b0, 1, beat(KIND_BYTE, 8'h00, 1'b1));
		// A space closes the open token.
		plan(CH_SPACE, 1'b1, 1'b0, 1, beat(KIND_EOT, 8'h00, 1'b1));
		// A hash on an empty token starts a comment; the byte after it is dropped.
		plan(CH_HASH, 1'b1, 1'b0, 0);
		plan(8'h78, 1'b1, 1'b1, 1, beat(KIND_EOL, 8'h00, 1'b1));
		// An empty quote pair leaves the token empty, so a hash still opens a comment.
		plan(CH_DQUOTE, 1'b1, 1'b0);
		plan(CH_DQUOTE, 1'b1, 1'b0);
		plan(CH_HASH, 1'b1, 1'b0);
		plan(8'h00, 1'b0, 1'b1, 1, beat(KIND_EOL, 8'h00, 1'b1));
		// A hash inside a token is an ordinary byte.
		plan(8'h61, 1'b1, 1'b0);
		plan(CH_HASH, 1'b1, 1'b0);
		// In double quotes a space and a single quote are literal.
		plan(CH_DQUOTE, 1'b1, 1'b0);
		plan(CH_SPACE, 1'b1, 1'b0);
		plan(CH_SQUOTE, 1'b1, 1'b0);
		// Newline and tab escapes.
		plan(CH_BSLASH, 1'b1, 1'b0);
		plan(CH_N, 1'b1, 1'b0);
		plan(CH_BSLASH, 1'b1, 1'b0);
		plan(CH_T, 1'b1, 1'b0);
		// An unknown escape together with end of line gives the largest burst:
		// backslash, the byte, end of token and end of line, with the quote unclosed.
		plan(CH_BSLASH, 1'b1, 1'b0);
		plan(8'h71, 1'b1, 1'b1);
		// In single quotes an escaped single quote gives the quote itself, and a
		// backslash left waiting at a bare end of line comes out as a literal.
		plan(CH_SQUOTE, 1'b1, 1'b0);
		plan(CH_BSLASH, 1'b1, 1'b0);
		plan(CH_SQUOTE, 1'b1, 1'b0);
		plan(CH_BSLASH, 1'b1, 1'b0);
		plan(8'hA5, 1'b0, 1'b1);
		// An item with neither a byte nor an end of line does nothing.
		plan(8'h5A, 1'b0, 1'b0, 0);
		// Outside quotes a backslash is an ordinary byte.
		plan(CH_BSLASH, 1'b1, 1'b1);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_steps[i]) begin
			if (directed_steps[i].want_count == FROM_PREDICTOR) begin
				send_predicted(directed_steps[i].char_code, directed_steps[i].has_char,
					directed_steps[i].end_of_line);
			end else begin
				offer_item(directed_steps[i].char_code, directed_steps[i].has_char,
					directed_steps[i].end_of_line);
				// The predictor still runs to keep its scan state in step.
				predict_tokens(directed_steps[i].char_code, directed_steps[i].has_char,
					directed_steps[i].end_of_line);
				for (int k = 0; k < directed_steps[i].want_count; k++)
					beats_due.insert(beats_due.size(), directed_steps[i].want[k]);
			end
		end

		// Random part: whole command lines with random content. A line ends
		// either on its last byte or with a bare end-of-line item, and empty
		// lines occur too. Now and then an empty item is slipped in as noise;
		// those are not counted. A stretch in the middle runs with no idling.
		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			line_len    = $urandom_range(0, 12);
			line_closed = 1'b0;
			for (int k = 0; k < line_len; k++) begin
				steady = (items_sent >= 50 && items_sent < 100);
				if ($urandom_range(0, 99) < 4)
					send_predicted(8'($urandom), 1'b0, 1'b0);
				eol = (k == line_len - 1) && ($urandom_range(0, 1) == 1);
				send_predicted(pick_line_char(), 1'b1, eol);
				line_closed = eol;
				items_sent++;
			end
			if (!line_closed) begin
				send_predicted(8'($urandom), 1'b0, 1'b1);
				items_sent++;
			end
		end
		steady = 1'b0;
		items.valid <= 1'b0;

		// Wait for every expected beat, then give stray results time to show up.
		while (beats_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && beats_due.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
